/* hdl/button_debounce_press_classifier_top_macros.svh */
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top_macros
// Assertion helpers for the button classifier.
// ----------------------------------------------------------------------------
// All checks are sampled on i_clk and are off while i_rst_n is low.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_MACROS_SVH

// Expression must hold at every sampled edge.
`define BDPC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define BDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bdpc_pkg.sv */
// ----------------------------------------------------------------------------
// bdpc_pkg
// Constants, types and the per-button update for the button classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int FIELD_W      = 4;   // width of every mask field
    localparam int SINCE_W      = 10;
    localparam int DUR_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [SINCE_W-1:0] SINCE_MAX      = '1;
    localparam logic [DUR_W-1:0]   DUR_MAX        = '1;
    localparam logic [SINCE_W-1:0] DEBOUNCE_RESET = SINCE_W'(50);
    localparam logic [DUR_W-1:0]   LONG_RESET     = DUR_W'(1000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = CFG_IDX_W'(1);

    typedef struct packed {
        logic               prev_raw;
        logic               stable;
        logic [SINCE_W-1:0] since;
        logic [DUR_W-1:0]   dur;
        logic               long_fired;
    } t_btn;

    typedef struct packed {
        t_btn st;
        logic short_hit;
        logic long_hit;
        logic rel_hit;
    } t_btn_res;

    localparam t_btn BTN_RESET = '{
        prev_raw:   1'b1,
        stable:     1'b1,
        since:      '0,
        dur:        '0,
        long_fired: 1'b0
    };

    // One tick of one button.
    function automatic t_btn_res btn_step(
        input t_btn               st,
        input logic               raw,
        input logic [SINCE_W-1:0] deb,
        input logic [DUR_W-1:0]   lpt
    );
        t_btn_res res;
        res           = '0;
        res.st        = st;

        if (raw != st.prev_raw) begin
            res.st.since = '0;
        end else if (st.since != SINCE_MAX) begin
            res.st.since = st.since + SINCE_W'(1);
        end

        if (!st.stable && st.dur != DUR_MAX) begin
            res.st.dur = st.dur + DUR_W'(1);
        end

        if (res.st.since > deb && raw != st.stable) begin
            res.st.stable = raw;
            if (!raw) begin
                res.st.dur        = '0;
                res.st.long_fired = 1'b0;
            end else begin
                res.short_hit = !st.long_fired && (res.st.dur < lpt);
                res.rel_hit   = 1'b1;
            end
        end

        if (!res.st.stable && res.st.dur >= lpt && !res.st.long_fired) begin
            res.long_hit      = 1'b1;
            res.st.long_fired = 1'b1;
        end

        res.st.prev_raw = raw;
        return res;
    endfunction

endpackage

/* hdl/button_debounce_press_classifier_top.sv */
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top
// Debounces four active-low buttons and flags short, long and release events.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -----------------------------
//  tick in   in         i_valid / o_stall         i_raw_levels
//  event out out        o_valid / i_stall         o_short_mask, o_long_mask,
//                                                 o_release_mask, o_stable_mask
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One tick beat per cycle while i_stall stays low; each beat goes through the
//  input register, then the per-button update into the result register.
//  The update is a single pass over the button counters: two saturating
//  increments and a compare against each setting, per button, all buttons
//  in parallel.
//  Reset (i_rst_n low, synchronous) releases all buttons, clears counters and
//  restores debounce 50 / long press 1000 ticks.
//  While the result register is held by i_stall, one more tick beat is still
//  taken into the input register; o_stall rises only when both are full.
//  Config writes are always ready and take effect on the next tick.
//
`include "button_debounce_press_classifier_top_macros.svh"

module button_debounce_press_classifier_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tick input
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bdpc_pkg::FIELD_W-1:0]   i_raw_levels,
    // event output
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bdpc_pkg::FIELD_W-1:0]   o_short_mask,
    output logic [bdpc_pkg::FIELD_W-1:0]   o_long_mask,
    output logic [bdpc_pkg::FIELD_W-1:0]   o_release_mask,
    output logic [bdpc_pkg::FIELD_W-1:0]   o_stable_mask,
    // config write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bdpc_pkg::*;

    // settings
    logic [SINCE_W-1:0] r_debounce;
    logic [DUR_W-1:0]   r_long_ticks;

    // input stage
    logic                    r_in_valid;
    logic [BUTTON_COUNT-1:0] r_in_raw;

    // per-button state
    t_btn r_btn [BUTTON_COUNT];
    t_btn n_btn [BUTTON_COUNT];

    // result stage
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_short;
    logic [FIELD_W-1:0] r_long;
    logic [FIELD_W-1:0] r_rel;
    logic [FIELD_W-1:0] r_stab;
    logic [FIELD_W-1:0] n_short;
    logic [FIELD_W-1:0] n_long;
    logic [FIELD_W-1:0] n_rel;
    logic [FIELD_W-1:0] n_stab;

    logic in_take;    // tick beat accepted
    logic out_block;  // result register cannot be refilled
    logic advance;    // input stage moves into result stage

    assign out_block = r_out_valid && i_stall;
    assign advance   = r_in_valid && !out_block;
    assign o_stall   = r_in_valid && out_block;
    assign in_take   = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    // per-button update, all buttons side by side
    always_comb begin
        t_btn_res res;
        n_short = '0;
        n_long  = '0;
        n_rel   = '0;
        n_stab  = '0;
        for (int b = 0; b < BUTTON_COUNT; b++) begin
            res        = btn_step(r_btn[b], r_in_raw[b], r_debounce, r_long_ticks);
            n_btn[b]   = res.st;
            n_short[b] = res.short_hit;
            n_long[b]  = res.long_hit;
            n_rel[b]   = res.rel_hit;
            n_stab[b]  = res.st.stable;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RESET;
            r_long_ticks <= LONG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DEBOUNCE: r_debounce   <= i_cfg_data[SINCE_W-1:0];
                REG_LONG:     r_long_ticks <= i_cfg_data[DUR_W-1:0];
                default:      ;  // unknown index, dropped
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_raw <= i_raw_levels[BUTTON_COUNT-1:0];
        end
    end

    // button state commits only when the tick moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                r_btn[b] <= BTN_RESET;
            end
        end else if (advance) begin
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                r_btn[b] <= n_btn[b];
            end
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_short <= n_short;
            r_long  <= n_long;
            r_rel   <= n_rel;
            r_stab  <= n_stab;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_short_mask   = r_short;
    assign o_long_mask    = r_long;
    assign o_release_mask = r_rel;
    assign o_stable_mask  = r_stab;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a long press only fires while the button is held down
    `BDPC_ASSERT_ALWAYS(a_long_while_pressed,
        !o_valid || ((o_long_mask & o_stable_mask) == '0), "long press on released button")
    // a short press always comes with a release
    `BDPC_ASSERT_ALWAYS(a_short_has_release,
        !o_valid || ((o_short_mask & ~o_release_mask) == '0), "short press without release")
    // a release leaves the button released
    `BDPC_ASSERT_ALWAYS(a_release_is_up,
        !o_valid || ((o_release_mask & ~o_stable_mask) == '0), "release but level pressed")
    // with both stages full and the output held, nothing is dropped
    `BDPC_ASSERT_NEXT(a_full_holds, r_in_valid && r_out_valid && i_stall,
        r_in_valid && r_out_valid, "beat lost while stalled")

endmodule

/* tb/tb_button_event_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_event_checker
// Watches the tick, event and register channels of the button classifier,
// predicts every event beat from the accepted ticks and compares them.
// ----------------------------------------------------------------------------
module tb_button_event_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tick_valid,
    input  logic                            i_tick_stall,
    input  logic [bdpc_pkg::FIELD_W-1:0]    i_raw_levels,
    input  logic                            i_evt_valid,
    input  logic                            i_evt_stall,
    input  logic [bdpc_pkg::FIELD_W-1:0]    i_short_mask,
    input  logic [bdpc_pkg::FIELD_W-1:0]    i_long_mask,
    input  logic [bdpc_pkg::FIELD_W-1:0]    i_release_mask,
    input  logic [bdpc_pkg::FIELD_W-1:0]    i_stable_mask,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_beats_checked,
    output int                              o_short_seen,
    output int                              o_long_seen,
    output int                              o_release_seen
);
    import bdpc_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] short_m;
        logic [FIELD_W-1:0] long_m;
        logic [FIELD_W-1:0] rel_m;
        logic [FIELD_W-1:0] stable_m;
    } t_tick_events;

    // predicted button state
    logic [BUTTON_COUNT-1:0] last_raw;
    logic [BUTTON_COUNT-1:0] settled;
    logic [BUTTON_COUNT-1:0] long_done;
    logic [SINCE_W-1:0]      quiet_ticks [BUTTON_COUNT];
    logic [DUR_W-1:0]        held_ticks  [BUTTON_COUNT];
    logic [SINCE_W-1:0]      debounce_cfg;
    logic [DUR_W-1:0]        long_cfg;

    t_tick_events pending_events [$];
    int           fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic t_tick_events classify_tick(input logic [FIELD_W-1:0] raw);
        t_tick_events ev;
        logic         r;
        ev = '0;
        for (int b = 0; b < BUTTON_COUNT; b++) begin
            r = raw[b];
            if (r != last_raw[b]) begin
                quiet_ticks[b] = '0;
            end else if (quiet_ticks[b] != SINCE_MAX) begin
                quiet_ticks[b] = quiet_ticks[b] + 1'b1;
            end
            if (!settled[b] && held_ticks[b] != DUR_MAX) begin
                held_ticks[b] = held_ticks[b] + 1'b1;
            end
            if (quiet_ticks[b] > debounce_cfg && r != settled[b]) begin
                settled[b] = r;
                if (!r) begin
                    held_ticks[b] = '0;
                    long_done[b]  = 1'b0;
                end else begin
                    ev.short_m[b] = !long_done[b] && (held_ticks[b] < long_cfg);
                    ev.rel_m[b]   = 1'b1;
                end
            end
            // long press judged on the level after this tick
            if (!settled[b] && held_ticks[b] >= long_cfg && !long_done[b]) begin
                ev.long_m[b] = 1'b1;
                long_done[b] = 1'b1;
            end
            last_raw[b] = r;
        end
        ev.stable_m = FIELD_W'(settled);
        return ev;
    endfunction

    function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                        input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_tick_events want;
        if (!i_rst_n) begin
            last_raw     = '1;
            settled      = '1;
            long_done    = '0;
            debounce_cfg = DEBOUNCE_RESET;
            long_cfg     = LONG_RESET;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                quiet_ticks[b] = '0;
                held_ticks[b]  = '0;
            end
            pending_events.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEBOUNCE: debounce_cfg = i_cfg_data[SINCE_W-1:0];
                    REG_LONG:     long_cfg     = i_cfg_data[DUR_W-1:0];
                    default: ;
                endcase
            end
            if (i_evt_valid && !i_evt_stall) begin
                if (pending_events.size() == 0) begin
                    $error("event beat arrived with no tick outstanding");
                    fail_total++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("short_mask",   want.short_m,  i_short_mask);
                    check_field("long_mask",    want.long_m,   i_long_mask);
                    check_field("release_mask", want.rel_m,    i_release_mask);
                    check_field("stable_mask",  want.stable_m, i_stable_mask);
                end
                o_beats_checked <= o_beats_checked + 1;
                o_short_seen    <= o_short_seen + $countones(i_short_mask);
                o_long_seen     <= o_long_seen + $countones(i_long_mask);
                o_release_seen  <= o_release_seen + $countones(i_release_mask);
            end
            if (i_tick_valid && !i_tick_stall) begin
                pending_events.push_back(classify_tick(i_raw_levels));
            end
            o_pending <= pending_events.size();
        end
    end

endmodule

/* tb/tb_button_debounce_press_classifier_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_debounce_press_classifier_top
// Drives millisecond tick beats and register writes into the button
// classifier under three pacing mixes; the checker beside it predicts and
// compares every event beat, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_button_debounce_press_classifier_top;
    import bdpc_pkg::*;

    // Spare register slots: writes there must leave the settings alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    // Directed tick patterns (bit low = pressed).
    // Debounce 0, long press 3: press all and hold past the long press, release
    // (no short after a long), a bounce in the middle of a press, then one
    // button pressed briefly for a short press.
    localparam logic [FIELD_W-1:0] PRESS_SEQ [19] = '{
        4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hF,
        4'hA, 4'hA, 4'h5, 4'hA, 4'hA, 4'hF, 4'hF,
        4'hE, 4'hE, 4'hF, 4'hF
    };
    // Long press 0: fires on the tick the press is taken, no short afterwards.
    localparam logic [FIELD_W-1:0] ZERO_LONG_SEQ [4] = '{4'h7, 4'h7, 4'hF, 4'hF};
    // Debounce at its ceiling: nothing is ever taken.
    localparam logic [FIELD_W-1:0] FROZEN_SEQ [2] = '{4'h0, 4'h0};

    localparam int SEGMENTS    = 9;
    localparam int SEG_ITEMS   = 100;
    localparam int SAT_PRESS   = 1040;    // long enough to pin the unchanged count
    localparam int SAT_RELEASE = 4;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [FIELD_W-1:0]    i_raw_levels = '1;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [FIELD_W-1:0]    o_short_mask;
    logic [FIELD_W-1:0]    o_long_mask;
    logic [FIELD_W-1:0]    o_release_mask;
    logic [FIELD_W-1:0]    o_stable_mask;
    logic                  o_cfg_ready;

    int fail_count;
    int pending;
    int beats_checked;
    int short_seen;
    int long_seen;
    int release_seen;

    // pacing knobs, percent of cycles
    int send_idle_pct  = 10;
    int recv_stall_pct = 52;
    int settings_count = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    button_debounce_press_classifier_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_raw_levels   (i_raw_levels),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_short_mask   (o_short_mask),
        .o_long_mask    (o_long_mask),
        .o_release_mask (o_release_mask),
        .o_stable_mask  (o_stable_mask),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    tb_button_event_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tick_valid    (i_valid),
        .i_tick_stall    (o_stall),
        .i_raw_levels    (i_raw_levels),
        .i_evt_valid     (o_valid),
        .i_evt_stall     (i_stall),
        .i_short_mask    (o_short_mask),
        .i_long_mask     (o_long_mask),
        .i_release_mask  (o_release_mask),
        .i_stable_mask   (o_stable_mask),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked),
        .o_short_seen    (short_seen),
        .o_long_seen     (long_seen),
        .o_release_seen  (release_seen)
    );

    // Receiver back-pressure: a fresh coin flip every cycle.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // One tick beat: idle cycles drawn one coin flip at a time, then the
    // payload is held until taken.
    task automatic send_tick(input logic [FIELD_W-1:0] raw);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid      <= 1'b0;
            i_raw_levels <= 4'($urandom);   // junk while idle
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_raw_levels <= raw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Stop sending and wait for every outstanding event beat.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // New settings only with the pipe empty, with spare idle cycles after the drain.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] deb_word,
                                  input logic [DUR_W-1:0] long_word);
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_reg(REG_DEBOUNCE, deb_word);
        write_reg(REG_LONG, CFG_DATA_W'(long_word));
        settings_count++;
    endtask

    initial begin
        logic [SINCE_W-1:0] deb;
        logic [DUR_W-1:0]   lng;
        logic [FIELD_W-1:0] target;
        int                 sent;
        int                 hold;
        int                 span;
        int                 budget;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------- directed ----------------
        apply_settings(CFG_DATA_W'(0), DUR_W'(3));
        foreach (PRESS_SEQ[k]) send_tick(PRESS_SEQ[k]);
        apply_settings(CFG_DATA_W'(0), '0);
        foreach (ZERO_LONG_SEQ[k]) send_tick(ZERO_LONG_SEQ[k]);
        // all-ones word: upper bits must be dropped, leaving 1023
        apply_settings('1, DUR_W'(20));
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, '1);
        foreach (FROZEN_SEQ[k]) send_tick(FROZEN_SEQ[k]);

        // ---------------- random ----------------
        // Segments 0-2: light sender gaps, heavy stalls; 3-5 the reverse;
        // 6-8 full rate both ways.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 3) begin
                send_idle_pct  = 52;
                recv_stall_pct = 10;
            end else if (seg == 6) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (seg)
                0: begin            // both settings at zero
                    deb = '0;
                    lng = '0;
                end
                4: begin            // long press out of reach: shorts only
                    deb = SINCE_W'(1);
                    lng = '1;
                end
                7: begin            // debounce ceiling, nothing accepted
                    deb = SINCE_MAX;
                    lng = DUR_W'($urandom_range(1, 24));
                end
                default: begin
                    deb = SINCE_W'($urandom_range(0, 6));
                    lng = DUR_W'($urandom_range(1, 24));
                end
            endcase
            apply_settings({(CFG_DATA_W-SINCE_W)'($urandom), deb}, lng);

            budget = (seg == 7) ? 40 : SEG_ITEMS;
            span   = int'(deb) + ((lng > 30) ? 30 : int'(lng)) + 8;
            if (span > 60) span = 60;
            sent = 0;
            while (sent < budget) begin
                if ($urandom_range(0, 99) < 15) begin
                    // pure noise
                    send_tick(4'($urandom));
                    sent++;
                end else begin
                    // contact bounce, then a steady level of random length, often long
                    // enough to settle and often long enough to reach the long press
                    target = 4'($urandom);
                    repeat ($urandom_range(0, 3)) begin
                        send_tick(4'($urandom));
                        sent++;
                    end
                    hold = $urandom_range(1, span);
                    repeat (hold) send_tick(target);
                    sent += hold;
                end
                if ($urandom_range(0, 99) < 3) wait_drained();
            end
        end

        // ---------------- saturation ----------------
        // Debounce at 1000: the press is taken once the unchanged count
        // passes it, and the count then pins at its ceiling.
        apply_settings(CFG_DATA_W'(1000), '1);
        repeat (SAT_PRESS) send_tick('0);
        // Zero debounce for a quick release; long press out of reach, so a
        // short press comes with it.
        apply_settings(CFG_DATA_W'(0), '1);
        repeat (SAT_RELEASE) send_tick('1);

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Checked %0d event beats: %0d short, %0d long, %0d release pulses",
                 beats_checked, short_seen, long_seen, release_seen);
        $display("Ran %0d register settings under three sender/receiver pacing mixes",
                 settings_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: reports a failure and stops if the run overruns its time limit.
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
